### rtl/rps_pkg.sv
// ----------------------------------------------------------------------------
// rps_pkg
// Shared constants and controller/datapath interface types for the reserved
// page set.
// ----------------------------------------------------------------------------
package rps_pkg;

   // Set size and derived widths
   localparam int CAPACITY   = 4096;
   localparam int IDX_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int COUNT_W    = $clog2(CAPACITY + 1);
   localparam int ADDR_W     = 52;
   localparam int ENTRY_W    = 13;
   localparam int PAGE_OFS_W = 12;

   // Item commands
   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_LOOKUP = 1'b1;

   // Commands from controller to datapath
   typedef struct packed {
      logic load;    // capture a new item, clear the search
      logic scan;    // step the search one entry
      logic finish;  // commit the insert and register the result
   } dp_cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic skip;      // new item is an unaligned lookup: no search needed
      logic scan_end;  // every held entry has been compared
      logic hit;       // address matched a held entry
   } dp_status_type;

endpackage

### rtl/rps_ram.sv
// ----------------------------------------------------------------------------
// rps_ram
// Generic single-clock RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module rps_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                         clock,
   input  logic                                         wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                             wr_data,
   input  logic                                         rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                             rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/rps_ctrl.sv
// ----------------------------------------------------------------------------
// rps_ctrl
// Controller for the reserved page set: accepts an item, runs the linear
// search, then commits and issues the result.
// ----------------------------------------------------------------------------
module rps_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  rps_pkg::dp_status_type status,
   output rps_pkg::dp_cmd_type    cmd
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SCAN   = 2'd1;
   localparam logic [1:0] ST_FINISH = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   // Next state and datapath commands
   always_comb begin
      state_in   = state_ff;
      cmd.load   = 1'b0;
      cmd.scan   = 1'b0;
      cmd.finish = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = status.skip ? ST_FINISH : ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (status.hit || status.scan_end) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            cmd.finish = 1'b1;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

### rtl/rps_dp.sv
// ----------------------------------------------------------------------------
// rps_dp
// Datapath for the reserved page set: item registers, scan index, entry
// count, address store and the result register.
// ----------------------------------------------------------------------------
module rps_dp (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_cmd,
   input  logic [rps_pkg::ADDR_W-1:0]            req_page_address,
   input  rps_pkg::dp_cmd_type                   cmd,
   output rps_pkg::dp_status_type                status,
   output logic                                  rsp_valid,
   output logic                                  rsp_found,
   output logic                                  rsp_full_error,
   output logic [rps_pkg::ENTRY_W-1:0]           rsp_entry_count
);

   // Item registers
   logic                          cmd_ff;
   logic [rps_pkg::ADDR_W-1:0]    addr_ff;

   // Search state
   logic [rps_pkg::COUNT_W-1:0]   idx_ff, idx_in;
   logic                          pend_ff, pend_in;
   logic                          hit_ff, hit_in;

   // Fill count of the address store
   logic [rps_pkg::COUNT_W-1:0]   count_ff, count_in;

   // Result register
   logic                          valid_ff;
   logic                          found_ff;
   logic                          err_ff;
   logic [rps_pkg::ENTRY_W-1:0]   entry_ff;

   // Store ports
   logic                          rd_en;
   logic [rps_pkg::ADDR_W-1:0]    rd_data;
   logic                          wr_en;

   logic                          full;
   logic                          drop;
   logic [rps_pkg::COUNT_W+rps_pkg::ENTRY_W-1:0] count_ext;

   rps_ram #(
      .WIDTH (rps_pkg::ADDR_W),
      .DEPTH (rps_pkg::CAPACITY)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[rps_pkg::IDX_W-1:0]),
      .wr_data (addr_ff),
      .rd_en   (rd_en),
      .rd_addr (idx_ff[rps_pkg::IDX_W-1:0]),
      .rd_data (rd_data)
   );

   // Unaligned lookups bypass the search
   assign status.skip     = (req_cmd == rps_pkg::CMD_LOOKUP) &&
                            (req_page_address[rps_pkg::PAGE_OFS_W-1:0] != '0);
   assign status.scan_end = (idx_ff == count_ff) && !pend_ff;
   assign status.hit      = hit_ff;

   // Commit decision
   assign full  = (count_ff == rps_pkg::COUNT_W'(rps_pkg::CAPACITY));
   assign drop  = (cmd_ff == rps_pkg::CMD_INSERT) && !hit_ff && full;
   assign wr_en = cmd.finish && (cmd_ff == rps_pkg::CMD_INSERT) && !hit_ff && !full;
   assign rd_en = cmd.scan && (idx_ff != count_ff);

   // Search and count next state
   always_comb begin
      idx_in   = idx_ff;
      pend_in  = 1'b0;
      hit_in   = hit_ff;
      count_in = count_ff;
      if (cmd.load) begin
         idx_in = '0;
         hit_in = 1'b0;
      end else if (cmd.scan) begin
         // one read issued per cycle, compared the cycle after
         if (pend_ff && (rd_data == addr_ff)) begin
            hit_in = 1'b1;
         end
         if (rd_en) begin
            idx_in  = idx_ff + 1'b1;
            pend_in = 1'b1;
         end
      end else if (wr_en) begin
         count_in = count_ff + 1'b1;
      end
   end

   assign count_ext = {{rps_pkg::ENTRY_W{1'b0}}, count_in};

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         pend_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         pend_ff  <= pend_in;
         valid_ff <= cmd.finish;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      hit_ff <= hit_in;
      if (cmd.load) begin
         cmd_ff  <= req_cmd;
         addr_ff <= req_page_address;
      end
      if (cmd.finish) begin
         found_ff <= hit_ff;
         err_ff   <= drop;
         entry_ff <= count_ext[rps_pkg::ENTRY_W-1:0];
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_found       = found_ff;
   assign rsp_full_error  = err_ff;
   assign rsp_entry_count = entry_ff;

endmodule

### rtl/reserved_page_set.sv
// ----------------------------------------------------------------------------
// reserved_page_set
// Set of physical page addresses with duplicate-free insert and lookup,
// searched linearly over the filled part of an address store.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake          Ports
//  --------  -----------------  ------------------------------------------
//  request   start & !busy      req_cmd, req_page_address
//  response  rsp_valid strobe   rsp_found, rsp_full_error, rsp_entry_count
//
// An accepted item is searched over the N entries held, stopping early on a
// hit (an unaligned lookup skips the search), then committed and its result
// strobed; the single read port compares one entry per cycle.
// Busy drops the cycle the result strobe rises, so a new item can follow.
// Reset clears the fill count and control state only; the store needs no clearing pass.
// The result is shown for one cycle; the receiver cannot stall it.
// ----------------------------------------------------------------------------
module reserved_page_set (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic                         req_cmd,
   input  logic [rps_pkg::ADDR_W-1:0]   req_page_address,
   output logic                         rsp_valid,
   output logic                         rsp_found,
   output logic                         rsp_full_error,
   output logic [rps_pkg::ENTRY_W-1:0]  rsp_entry_count
);

   rps_pkg::dp_cmd_type    dp_cmd;
   rps_pkg::dp_status_type dp_status;

   // Sequencer
   rps_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (dp_status),
      .cmd    (dp_cmd)
   );

   // Store, search and result
   rps_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .req_cmd          (req_cmd),
      .req_page_address (req_page_address),
      .cmd              (dp_cmd),
      .status           (dp_status),
      .rsp_valid        (rsp_valid),
      .rsp_found        (rsp_found),
      .rsp_full_error   (rsp_full_error),
      .rsp_entry_count  (rsp_entry_count)
   );

endmodule

### sim/reserved_page_set_tb.sv
// ----------------------------------------------------------------------------
// reserved_page_set_tb
// Self-checking bench for the reserved page set. Insert and lookup items are
// sent through the start/busy port. A behavioural copy of the set predicts
// found, full_error and entry_count for each accepted item. Each result
// strobe is checked against the oldest prediction. The run covers directed
// edge cases, random traffic under three sender idle profiles, and a fill of
// the set to capacity that exercises the full-set error.
// ----------------------------------------------------------------------------
module reserved_page_set_tb;
   timeunit 1ns;
   timeprecision 1ps;

   // Well above the slowest correct run; the fill of the set takes the longest
   localparam int CYCLE_LIMIT   = 40_000_000;
   localparam int RANDOM_ITEMS  = 47;
   localparam int MAX_GAP       = 20;
   localparam int TAIL_CYCLES   = 10;

   typedef struct packed {
      logic                        found;
      logic                        full_error;
      logic [rps_pkg::ENTRY_W-1:0] entry_count;
   } page_result_type;

   logic                         clock            = 1'b0;
   logic                         reset            = 1'b1;
   logic                         start            = 1'b0;
   logic                         req_cmd          = rps_pkg::CMD_INSERT;
   logic [rps_pkg::ADDR_W-1:0]   req_page_address = '0;
   logic                         busy;
   logic                         rsp_valid;
   logic                         rsp_found;
   logic                         rsp_full_error;
   logic [rps_pkg::ENTRY_W-1:0]  rsp_entry_count;

   // Shadow of the set and the predicted results still to arrive
   bit                           held_pages [logic [rps_pkg::ADDR_W-1:0]];
   int                           held_count   = 0;
   page_result_type              pending_results [$];
   logic [rps_pkg::ADDR_W-1:0]   seen_addresses [$];
   int                           idle_percent = 0;
   int                           error_count  = 0;
   int                           cycle_count  = 0;

   reserved_page_set i_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_cmd          (req_cmd),
      .req_page_address (req_page_address),
      .rsp_valid        (rsp_valid),
      .rsp_found        (rsp_found),
      .rsp_full_error   (rsp_full_error),
      .rsp_entry_count  (rsp_entry_count)
   );

   always #5 clock = ~clock;

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles", $time, cycle_count);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // Work out the result of one item and update the shadow set
   function automatic page_result_type predict_page_result(
      input logic                       cmd,
      input logic [rps_pkg::ADDR_W-1:0] addr);
      page_result_type res;
      res = '0;
      if (cmd == rps_pkg::CMD_INSERT) begin
         if (held_pages.exists(addr)) begin
            res.found = 1'b1;
         end else if (held_count >= rps_pkg::CAPACITY) begin
            res.full_error = 1'b1;
         end else begin
            held_pages[addr] = 1'b1;
            held_count++;
         end
      end else if (addr[rps_pkg::PAGE_OFS_W-1:0] == '0 && held_pages.exists(addr)) begin
         res.found = 1'b1;
      end
      res.entry_count = rps_pkg::ENTRY_W'(held_count);
      return res;
   endfunction

   function automatic logic [rps_pkg::ADDR_W-1:0] random_address();
      logic [63:0] word;
      word = {$urandom, $urandom};
      return word[rps_pkg::ADDR_W-1:0];
   endfunction

   // Present one item and hold it until accepted; an optional gap first
   task automatic send_item(input logic cmd, input logic [rps_pkg::ADDR_W-1:0] addr);
      int gap;
      if ($urandom_range(99) < idle_percent) begin
         gap = $urandom_range(1, MAX_GAP);
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start            <= 1'b1;
      req_cmd          <= cmd;
      req_page_address <= addr;
      @(posedge clock);
      while (busy) @(posedge clock);
      pending_results.push_back(predict_page_result(cmd, addr));
      seen_addresses.push_back(addr);
   endtask

   task automatic wait_for_results();
      start <= 1'b0;
      while (pending_results.size() > 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
   endtask

   // Result checker: every strobe must match the oldest prediction
   always @(posedge clock) begin
      page_result_type exp_res;
      if (!reset && rsp_valid) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result found=%0b full_error=%0b entry_count=%0d",
                     $time, rsp_found, rsp_full_error, rsp_entry_count);
            error_count++;
         end else begin
            exp_res = pending_results.pop_front();
            if (rsp_found !== exp_res.found) begin
               $display("%0t: found expected %0b actual %0b",
                        $time, exp_res.found, rsp_found);
               error_count++;
            end
            if (rsp_full_error !== exp_res.full_error) begin
               $display("%0t: full_error expected %0b actual %0b",
                        $time, exp_res.full_error, rsp_full_error);
               error_count++;
            end
            if (rsp_entry_count !== exp_res.entry_count) begin
               $display("%0t: entry_count expected %0d actual %0d",
                        $time, exp_res.entry_count, rsp_entry_count);
               error_count++;
            end
         end
      end
   end

   // Edge cases: empty set, address extremes, duplicates, unaligned addresses
   task automatic test_directed_cases();
      idle_percent = 0;
      send_item(rps_pkg::CMD_LOOKUP, '0);                     // miss on empty set
      send_item(rps_pkg::CMD_INSERT, '0);
      send_item(rps_pkg::CMD_LOOKUP, '0);
      send_item(rps_pkg::CMD_INSERT, '0);                     // duplicate
      send_item(rps_pkg::CMD_INSERT, '1);                     // unaligned, still stored
      send_item(rps_pkg::CMD_LOOKUP, '1);                     // unaligned never hits
      send_item(rps_pkg::CMD_INSERT, '1);                     // duplicate of unaligned
      send_item(rps_pkg::CMD_INSERT, 52'hF_FFFF_FFFF_F000);   // highest aligned page
      send_item(rps_pkg::CMD_LOOKUP, 52'hF_FFFF_FFFF_F000);
      send_item(rps_pkg::CMD_LOOKUP, 52'h0_0000_0000_1000);
      send_item(rps_pkg::CMD_INSERT, 52'h0_0000_0000_0001);
      send_item(rps_pkg::CMD_LOOKUP, 52'h0_0000_0000_0001);
      send_item(rps_pkg::CMD_INSERT, 52'hA_AAAA_AAAA_A000);
      send_item(rps_pkg::CMD_INSERT, 52'h5_5555_5555_5000);
      send_item(rps_pkg::CMD_LOOKUP, 52'hA_AAAA_AAAA_A000);
      send_item(rps_pkg::CMD_LOOKUP, 52'h5_5555_5555_5000);
      send_item(rps_pkg::CMD_LOOKUP, 52'h5_5555_5555_5800);   // near miss in the offset
      send_item(rps_pkg::CMD_LOOKUP, 52'h8_0000_0000_0000);
   endtask

   // Random mix: half the items reuse an address already seen, so hits and duplicates occur
   task automatic test_random_traffic(input int idle_pct);
      logic                       cmd;
      logic [rps_pkg::ADDR_W-1:0] addr;
      int                         pick;
      idle_percent = idle_pct;
      repeat (RANDOM_ITEMS) begin
         cmd  = $urandom_range(1) ? rps_pkg::CMD_LOOKUP : rps_pkg::CMD_INSERT;
         pick = $urandom_range(99);
         addr = seen_addresses[$urandom_range(seen_addresses.size() - 1)];
         if (pick < 15) begin
            addr = random_address();
            addr[rps_pkg::PAGE_OFS_W-1:0] = '0;
         end else if (pick < 30) begin
            addr = random_address();
         end else if (pick < 40) begin
            addr[rps_pkg::PAGE_OFS_W-1:0] = rps_pkg::PAGE_OFS_W'($urandom);
         end else if (pick < 50) begin
            addr = addr ^ (52'd1 << $urandom_range(rps_pkg::ADDR_W - 1));
         end
         send_item(cmd, addr);
      end
   endtask

   // Fill the set, then check behaviour of a full set
   task automatic test_fill_to_capacity();
      logic [rps_pkg::ADDR_W-1:0] addr;
      logic [rps_pkg::ADDR_W-1:0] last_page;
      idle_percent = 0;
      last_page    = '0;
      while (held_count < rps_pkg::CAPACITY) begin
         addr = random_address();
         addr[rps_pkg::PAGE_OFS_W-1:0] = '0;
         send_item(rps_pkg::CMD_INSERT, addr);
         last_page = addr;
      end
      idle_percent = 33;
      send_item(rps_pkg::CMD_INSERT, 52'h1_2345_6789_A000 ^ last_page);   // dropped
      send_item(rps_pkg::CMD_INSERT, last_page);                  // duplicate, no error
      send_item(rps_pkg::CMD_INSERT, '1);                         // held unaligned
      send_item(rps_pkg::CMD_LOOKUP, last_page);
      send_item(rps_pkg::CMD_LOOKUP, '0);
      send_item(rps_pkg::CMD_LOOKUP, '1);
      send_item(rps_pkg::CMD_LOOKUP, last_page ^ 52'h0_0000_0000_1000);
      send_item(rps_pkg::CMD_INSERT, random_address());
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_cases();
      test_random_traffic(33);
      test_random_traffic(78);
      test_random_traffic(0);
      test_fill_to_capacity();
      wait_for_results();
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
